@@ rtl/core/chi_pkg.sv @@
package chi_pkg;

	// Table geometry
	localparam int BUCKET_COUNT = 13;
	localparam int POOL_NODES   = 64;

	// Field widths of the stream items
	localparam int KEY_W        = 31;
	localparam int STATUS_W     = 2;
	localparam int BUCKET_OUT_W = 4;
	localparam int S_TDATA_W    = 32;
	localparam int M_TDATA_W    = 8;

	// Internal widths
	localparam int BKT_W   = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
	localparam int NODE_W  = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
	localparam int USED_W  = $clog2(POOL_NODES + 1);
	localparam int DIGIT_W = 4;
	localparam int NIB_STEPS = (KEY_W + DIGIT_W - 1) / DIGIT_W;
	localparam int PAD_W   = NIB_STEPS * DIGIT_W;
	localparam int CNT_W   = $clog2(NIB_STEPS + 1);
	localparam int RED_W   = BKT_W + DIGIT_W;

	// Result codes
	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 2'd0,
		ST_DUPLICATE = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	// Classified request handed from the front to the back
	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [BKT_W-1:0] bucket;
	} job_t;

	// One word of the node pool
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic              has_next;
		logic [NODE_W-1:0] next;
	} node_t;

	// One radix-16 remainder step: v < 16 * BUCKET_COUNT, result < BUCKET_COUNT
	function automatic logic [BKT_W-1:0] mod_step(input logic [RED_W-1:0] v);
		logic [RED_W-1:0] r;
		logic [RED_W-1:0] thr;
		r = v;
		for (int j = 1; j < (1 << DIGIT_W); j++) begin
			thr = RED_W'(j * BUCKET_COUNT);
			if (v >= thr) begin
				r = v - thr;
			end
		end
		return r[BKT_W-1:0];
	endfunction

endpackage

@@ rtl/core/chi_front.sv @@
module chi_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [chi_pkg::KEY_W-1:0] in_key,
	output logic                      job_valid,
	input  logic                      job_ready,
	output chi_pkg::job_t             job
);

	logic                        busy_q;
	logic [chi_pkg::CNT_W-1:0]   cnt_q;
	logic [chi_pkg::KEY_W-1:0]   key_q;
	logic [chi_pkg::PAD_W-1:0]   shift_q;
	logic [chi_pkg::BKT_W-1:0]   rem_q;
	logic                        done;

	assign done      = (cnt_q == chi_pkg::CNT_W'(chi_pkg::NIB_STEPS));
	assign in_ready  = !busy_q;
	assign job_valid = busy_q && done;
	assign job.key    = key_q;
	assign job.bucket = rem_q;

	// Sequence one request: take it, reduce one hex digit a cycle, hand it on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (!busy_q) begin
			if (in_valid) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
		end else if (!done) begin
			cnt_q <= cnt_q + chi_pkg::CNT_W'(1);
		end else if (job_ready) begin
			busy_q <= 1'b0;
		end
	end

	// Remainder datapath, most significant digit first
	always_ff @(posedge clk) begin
		if (!busy_q && in_valid) begin
			key_q   <= in_key;
			shift_q <= chi_pkg::PAD_W'(in_key);
			rem_q   <= '0;
		end else if (busy_q && !done) begin
			rem_q   <= chi_pkg::mod_step({rem_q,
				shift_q[chi_pkg::PAD_W-1 -: chi_pkg::DIGIT_W]});
			shift_q <= shift_q << chi_pkg::DIGIT_W;
		end
	end

endmodule

@@ rtl/core/chi_fifo.sv @@
module chi_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  chi_pkg::job_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output chi_pkg::job_t pop_data
);

	chi_pkg::job_t slot_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          push;
	logic          pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// Store the request
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ rtl/core/chi_back.sv @@
module chi_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             job_valid,
	output logic                             job_ready,
	input  chi_pkg::job_t                    job,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [chi_pkg::STATUS_W-1:0]     out_status,
	output logic [chi_pkg::BUCKET_OUT_W-1:0] out_bucket
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_HEAD,
		S_WALK,
		S_LINK,
		S_RESP
	} state_t;

	state_t                       state_q;
	chi_pkg::job_t                job_q;
	logic                         head_valid_q [chi_pkg::BUCKET_COUNT];
	logic [chi_pkg::NODE_W-1:0]   head_node_q  [chi_pkg::BUCKET_COUNT];
	logic [chi_pkg::USED_W-1:0]   used_q;
	logic [chi_pkg::NODE_W-1:0]   cur_q;
	chi_pkg::status_t             status_q;
	logic                         out_valid_q;
	logic [chi_pkg::STATUS_W-1:0] out_status_q;
	logic [chi_pkg::BUCKET_OUT_W-1:0] out_bucket_q;

	// Node pool memory
	chi_pkg::node_t               node_mem [chi_pkg::POOL_NODES];
	chi_pkg::node_t               node_rd_q;
	logic                         mem_we;
	logic [chi_pkg::NODE_W-1:0]   mem_waddr;
	chi_pkg::node_t               mem_wdata;
	logic [chi_pkg::NODE_W-1:0]   mem_raddr;

	logic                         pool_free;
	logic [chi_pkg::NODE_W-1:0]   fresh;
	logic                         hit;

	assign pool_free  = (used_q < chi_pkg::USED_W'(chi_pkg::POOL_NODES));
	assign fresh      = used_q[chi_pkg::NODE_W-1:0];
	assign hit        = (node_rd_q.key == job_q.key);
	assign job_ready  = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign out_status = out_status_q;
	assign out_bucket = out_bucket_q;

	// Drive memory ports from the walk state
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = fresh;
		mem_wdata = '{key: job_q.key, has_next: 1'b0, next: '0};
		mem_raddr = cur_q;
		case (state_q)
			S_HEAD: begin
				if (!head_valid_q[job_q.bucket]) begin
					mem_we = pool_free;
				end else begin
					mem_raddr = head_node_q[job_q.bucket];
				end
			end
			S_WALK: begin
				if (!hit && node_rd_q.has_next) begin
					mem_raddr = node_rd_q.next;
				end else if (!hit && pool_free) begin
					// link the tail to the node about to be taken
					mem_we    = 1'b1;
					mem_waddr = cur_q;
					mem_wdata = '{key: node_rd_q.key, has_next: 1'b1, next: fresh};
				end
			end
			S_LINK: begin
				mem_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			node_mem[mem_waddr] <= mem_wdata;
		end
		node_rd_q <= node_mem[mem_raddr];
	end

	// Walk controller and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			job_q        <= '0;
			used_q       <= '0;
			cur_q        <= '0;
			status_q     <= chi_pkg::ST_INSERTED;
			out_valid_q  <= 1'b0;
			out_status_q <= '0;
			out_bucket_q <= '0;
			for (int i = 0; i < chi_pkg::BUCKET_COUNT; i++) begin
				head_valid_q[i] <= 1'b0;
				head_node_q[i]  <= '0;
			end
		end else begin
			// Drop the response once taken, unless a new one loads this cycle
			if (out_valid_q && out_ready && state_q != S_RESP) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						job_q   <= job;
						state_q <= S_HEAD;
					end
				end
				S_HEAD: begin
					if (!head_valid_q[job_q.bucket]) begin
						if (pool_free) begin
							head_valid_q[job_q.bucket] <= 1'b1;
							head_node_q[job_q.bucket]  <= fresh;
							used_q   <= used_q + chi_pkg::USED_W'(1);
							status_q <= chi_pkg::ST_INSERTED;
						end else begin
							status_q <= chi_pkg::ST_FULL;
						end
						state_q <= S_RESP;
					end else begin
						cur_q   <= head_node_q[job_q.bucket];
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (hit) begin
						status_q <= chi_pkg::ST_DUPLICATE;
						state_q  <= S_RESP;
					end else if (node_rd_q.has_next) begin
						cur_q <= node_rd_q.next;
					end else if (pool_free) begin
						state_q <= S_LINK;
					end else begin
						status_q <= chi_pkg::ST_FULL;
						state_q  <= S_RESP;
					end
				end
				S_LINK: begin
					used_q   <= used_q + chi_pkg::USED_W'(1);
					status_q <= chi_pkg::ST_INSERTED;
					state_q  <= S_RESP;
				end
				S_RESP: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= status_q;
						out_bucket_q <= chi_pkg::BUCKET_OUT_W'(job_q.bucket);
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/core/chained_hash_insert.sv @@
// Hash table insert with separate chaining. Each request on s_axis carries a
// 31-bit key; the block returns one response on m_axis with a status (inserted,
// duplicate, pool full) and the bucket, key modulo 13. The front accepts a
// request, reduces the key one hex digit a cycle and hands it to a two-entry
// queue, waiting while the queue is full, so it takes the next request while
// the back still walks. The back takes one request at a time from the queue,
// reads the bucket head, walks the chain node by node through the node memory
// (a write port and a separate read port), takes an extra step when appending,
// and loads the response register once the previous response has been taken.
// No clearing pass is needed after reset; the bucket-valid flags clear at once.
module chained_hash_insert (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [chi_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [30:0] insert_key
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [chi_pkg::M_TDATA_W-1:0] m_axis_tdata   // [1:0] status, [5:2] bucket
);

	logic                             job_in_valid;
	logic                             job_in_ready;
	chi_pkg::job_t                    job_in;
	logic                             job_out_valid;
	logic                             job_out_ready;
	chi_pkg::job_t                    job_out;
	logic [chi_pkg::STATUS_W-1:0]     status;
	logic [chi_pkg::BUCKET_OUT_W-1:0] bucket;

	// Accept and classify
	chi_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_key    (s_axis_tdata[chi_pkg::KEY_W-1:0]),
		.job_valid (job_in_valid),
		.job_ready (job_in_ready),
		.job       (job_in)
	);

	// Decouple front and back
	chi_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (job_in_valid),
		.push_ready (job_in_ready),
		.push_data  (job_in),
		.pop_valid  (job_out_valid),
		.pop_ready  (job_out_ready),
		.pop_data   (job_out)
	);

	// Walk the chain and insert
	chi_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (job_out_valid),
		.job_ready  (job_out_ready),
		.job        (job_out),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (status),
		.out_bucket (bucket)
	);

	assign m_axis_tdata = chi_pkg::M_TDATA_W'({bucket, status});

endmodule

@@ tb/tb_chained_hash_insert.sv @@
module tb_chained_hash_insert;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     RESET_CYCLES  = 5;
	localparam int     PHASE_ITEMS   = 444;
	localparam int     HOLD_CYCLES   = 400;
	localparam int     DRAIN_CYCLES  = 2 * chi_pkg::POOL_NODES + 16;
	localparam int     CYCLE_LIMIT   = 1000000;
	localparam int     CHAIN_BUCKET  = 5;
	localparam longint KEY_MAX       = (longint'(1) << chi_pkg::KEY_W) - 1;
	localparam int     PHASE_RX_SLOW = 0;
	localparam int     PHASE_TX_SLOW = 1;
	localparam int     PHASE_FREE    = 2;
	localparam int     DIRECTED_N    = 18;

	// Edge keys, chain append, mid and tail duplicates, masked top bit
	localparam logic [chi_pkg::S_TDATA_W-1:0] DIRECTED [DIRECTED_N] = '{
		32'h0000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
		32'h0000_000C, 32'h0000_000D, 32'h0000_001A, 32'h0000_0027,
		32'h0000_000D, 32'h0000_0027, 32'h8000_0000, 32'h8000_000D,
		32'h5555_5555, 32'h2AAA_AAAA, 32'h0000_0001, 32'h7FFF_FFFE,
		32'h2AAA_AAAA, 32'h0000_0034
	};

	typedef struct packed {
		chi_pkg::status_t                 status;
		logic [chi_pkg::BUCKET_OUT_W-1:0] bucket;
	} insert_result_t;

	// Shadow of the table: predicts the response of every accepted request
	class insert_scoreboard;
		bit                         head_valid [chi_pkg::BUCKET_COUNT];
		logic [chi_pkg::NODE_W-1:0] head_node  [chi_pkg::BUCKET_COUNT];
		logic [chi_pkg::KEY_W-1:0]  node_key   [chi_pkg::POOL_NODES];
		bit                         node_has_next [chi_pkg::POOL_NODES];
		logic [chi_pkg::NODE_W-1:0] node_next  [chi_pkg::POOL_NODES];
		int                         nodes_used;
		insert_result_t             pending [$];
		int                         errors;

		function new();
			foreach (head_valid[i]) head_valid[i] = 1'b0;
			nodes_used = 0;
			errors = 0;
		endfunction

		// Claim a fresh node for key; returns 0 when the pool is used up
		function bit claim_node(input logic [chi_pkg::KEY_W-1:0] key,
				output logic [chi_pkg::NODE_W-1:0] idx);
			if (nodes_used >= chi_pkg::POOL_NODES) begin
				return 1'b0;
			end
			idx = chi_pkg::NODE_W'(nodes_used);
			node_key[idx] = key;
			node_has_next[idx] = 1'b0;
			node_next[idx] = '0;
			nodes_used++;
			return 1'b1;
		endfunction

		function void note_request(input logic [chi_pkg::S_TDATA_W-1:0] word);
			logic [chi_pkg::KEY_W-1:0]  key;
			int unsigned                b;
			logic [chi_pkg::NODE_W-1:0] cur;
			logic [chi_pkg::NODE_W-1:0] fresh;
			bit                         dup;
			insert_result_t             res;
			key = word[chi_pkg::KEY_W-1:0];
			b = key % chi_pkg::BUCKET_COUNT;
			dup = 1'b0;
			if (!head_valid[b]) begin
				if (claim_node(key, fresh)) begin
					head_valid[b] = 1'b1;
					head_node[b] = fresh;
					res.status = chi_pkg::ST_INSERTED;
				end else begin
					res.status = chi_pkg::ST_FULL;
				end
			end else begin
				// Walk the chain, stopping on a match or at the tail
				cur = head_node[b];
				for (int n = 0; n < chi_pkg::POOL_NODES; n++) begin
					if (node_key[cur] == key) begin
						dup = 1'b1;
						break;
					end
					if (!node_has_next[cur]) begin
						break;
					end
					cur = node_next[cur];
				end
				if (dup) begin
					res.status = chi_pkg::ST_DUPLICATE;
				end else if (claim_node(key, fresh)) begin
					node_has_next[cur] = 1'b1;
					node_next[cur] = fresh;
					res.status = chi_pkg::ST_INSERTED;
				end else begin
					res.status = chi_pkg::ST_FULL;
				end
			end
			res.bucket = chi_pkg::BUCKET_OUT_W'(b);
			pending.push_back(res);
		endfunction

		function void check_response(input logic [chi_pkg::M_TDATA_W-1:0] word);
			insert_result_t                   want;
			logic [chi_pkg::STATUS_W-1:0]     got_status;
			logic [chi_pkg::BUCKET_OUT_W-1:0] got_bucket;
			got_status = word[chi_pkg::STATUS_W-1:0];
			got_bucket = word[chi_pkg::STATUS_W +: chi_pkg::BUCKET_OUT_W];
			if (pending.size() == 0) begin
				$error("unexpected response: status %0d bucket %0d", got_status, got_bucket);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got_status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got_status);
				errors++;
			end
			if (got_bucket !== want.bucket) begin
				$error("bucket: expected %0d, got %0d", want.bucket, got_bucket);
				errors++;
			end
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [chi_pkg::S_TDATA_W-1:0] s_tdata = '0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [chi_pkg::M_TDATA_W-1:0] m_tdata;

	int                        stim_phase = PHASE_RX_SLOW;
	int                        hold_left = 0;
	bit                        hold_done = 1'b0;
	int                        cycle_count = 0;
	logic [chi_pkg::KEY_W-1:0] offered_keys [$];
	insert_scoreboard          sb = new();

	chained_hash_insert dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_tready),
		.s_axis_tdata  (s_tdata),
		.m_axis_tvalid (m_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_tdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Stop a hung run
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_chained_hash_insert: done, errors");
		$finish;
	end

	// Note accepted requests and check responses
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				sb.note_request(s_tdata);
			end
			if (m_tvalid && m_tready) begin
				sb.check_response(m_tdata);
			end
		end
	end

	// Drive the response side; hold off once for a long stretch in the last phase
	always @(posedge clk) begin
		if (stim_phase == PHASE_FREE && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case (stim_phase)
				PHASE_RX_SLOW: m_tready <= ($urandom_range(99) >= 55);
				PHASE_TX_SLOW: m_tready <= ($urandom_range(99) >= 8);
				default:       m_tready <= 1'b1;
			endcase
		end
	end

	// Offer one request, idling first with the given chance per cycle
	task automatic send_word(input logic [chi_pkg::S_TDATA_W-1:0] word, input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		do @(posedge clk); while (!s_tready);
		offered_keys.push_back(word[chi_pkg::KEY_W-1:0]);
	endtask

	// Mix repeats, one crowded bucket, edge keys and plain random keys
	function automatic logic [chi_pkg::S_TDATA_W-1:0] pick_word();
		logic [chi_pkg::KEY_W-1:0] k;
		int                        roll;
		roll = $urandom_range(99);
		if (roll < 35 && offered_keys.size() > 0) begin
			k = offered_keys[$urandom_range(offered_keys.size() - 1)];
		end else if (roll < 55) begin
			k = chi_pkg::KEY_W'(chi_pkg::BUCKET_COUNT *
				$urandom_range(int'((KEY_MAX - CHAIN_BUCKET) / chi_pkg::BUCKET_COUNT))
				+ CHAIN_BUCKET);
		end else if (roll < 65) begin
			case ($urandom_range(3))
				0:       k = '0;
				1:       k = '1;
				2:       k = '1 - chi_pkg::KEY_W'($urandom_range(chi_pkg::BUCKET_COUNT - 1));
				default: k = chi_pkg::KEY_W'($urandom_range(chi_pkg::BUCKET_COUNT - 1));
			endcase
		end else begin
			k = chi_pkg::KEY_W'($urandom);
		end
		// Padding bit above the key now and then; the block must ignore it
		return {($urandom_range(15) == 0), k};
	endfunction

	initial begin
		int tx_pct;
		wait (arst_n);
		@(posedge clk);

		// Directed keys first
		foreach (DIRECTED[i]) begin
			send_word(DIRECTED[i], 8);
		end

		// Random requests under three idling patterns
		for (int p = PHASE_RX_SLOW; p <= PHASE_FREE; p++) begin
			stim_phase <= p;
			case (p)
				PHASE_RX_SLOW: tx_pct = 8;
				PHASE_TX_SLOW: tx_pct = 55;
				default:       tx_pct = 0;
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_word(pick_word(), tx_pct);
			end
		end
		s_tvalid <= 1'b0;

		// Drain outstanding responses
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0) begin
			$display("tb_chained_hash_insert: done, clean");
		end else begin
			$display("tb_chained_hash_insert: done, errors");
		end
		$finish;
	end

endmodule
